// ===== rtl/assert_macros.svh =====
// Assertion macros for the scatter-elements reduce unit.
// Clocked on aclk and disabled while aresetn is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SERE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SERE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sere_pkg.sv =====
// Shared types and codes for the scatter-elements reduce unit.
// No dependencies; used by sere_alu and scatter_elements_reduce_unit.
package sere_pkg;

    localparam int MODE_W    = 3;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 13;
    localparam int COORD_W   = 12;
    localparam int POS_W     = 13;
    localparam int DST_W     = 28;
    localparam int DIM_W     = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCATTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ASSIGN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX    = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_ADDR  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALEN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE3 = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              mul_clear;
        logic              mul_step;
    } alu_ctl_t;

endpackage

// ===== rtl/sere_alu.sv =====
// Reduction unit: assign, add, signed min/max, and a multiply stepped over a
// shared 32x32 multiplier. Depends on sere_pkg.
module sere_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sere_pkg::alu_ctl_t    ctl,
    input  logic [DATA_WIDTH-1:0] old_val,
    input  logic [DATA_WIDTH-1:0] upd_val,
    output logic [DATA_WIDTH-1:0] result,
    output logic                  mul_last
);

    localparam logic [1:0] LAST_STEP = (DATA_WIDTH > 32) ? 2'd2 : 2'd0;

    logic [1:0]  step_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] a64;
    logic [63:0] b64;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [63:0] prod;
    logic [63:0] shifted;

    assign a64 = 64'(old_val);
    assign b64 = 64'(upd_val);

    always_comb begin
        case (step_reg)
            2'd0: begin
                opa = a64[31:0];
                opb = b64[31:0];
            end
            2'd1: begin
                opa = a64[31:0];
                opb = b64[63:32];
            end
            default: begin
                opa = a64[63:32];
                opb = b64[31:0];
            end
        endcase
    end

    assign prod     = 64'(opa) * 64'(opb);
    assign shifted  = (step_reg == 2'd0) ? prod : {prod[31:0], 32'b0};
    assign acc_next = acc_reg + shifted;
    assign mul_last = (step_reg == LAST_STEP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 2'd0;
        end else if (ctl.mul_clear) begin
            step_reg <= 2'd0;
        end else if (ctl.mul_step) begin
            step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_clear) begin
            acc_reg <= '0;
        end else if (ctl.mul_step) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        case (ctl.mode)
            sere_pkg::MODE_ADD: result = old_val + upd_val;
            sere_pkg::MODE_MUL: result = DATA_WIDTH'(acc_next);
            sere_pkg::MODE_MIN: result = ($signed(old_val) < $signed(upd_val)) ? old_val : upd_val;
            sere_pkg::MODE_MAX: result = ($signed(upd_val) < $signed(old_val)) ? old_val : upd_val;
            default:            result = upd_val;
        endcase
    end

endmodule

// ===== rtl/scatter_elements_reduce_unit.sv =====
// Top level of the scatter-elements reduce unit: APB register file, command
// sequencer and the element store. Depends on sere_pkg, sere_alu, assert_macros.svh.
//
// Takes one transaction at a time and answers each with exactly one result.
// The destination address is built by one 13x13 multiplier that handles one
// dimension per cycle, and the update is a read-modify-write of the single
// store, whose read data arrives in the cycle after the address.
// Multiply reduction runs through one shared 32x32 multiplier. A finished
// result sits in the output register, so the block frees up while the
// consumer stalls unless a second result is ready to leave.
`include "assert_macros.svh"

module scatter_elements_reduce_unit #(
    parameter int DEPTH      = 4096,
    parameter int MAX_RANK   = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [11:0]         s_flat_addr,
    input  logic [11:0]         s_coord0,
    input  logic [11:0]         s_coord1,
    input  logic [11:0]         s_coord2,
    input  logic [11:0]         s_coord3,
    input  logic signed [12:0]  s_axis_index,
    input  logic signed [31:0]  s_value,

    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_read_data,
    output logic [1:0]          m_status
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [sere_pkg::DIM_W-1:0] LAST_DIM = sere_pkg::DIM_W'(MAX_RANK - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_ADDR   = 7'b0000100,
        ST_CHK    = 7'b0001000,
        ST_RDWAIT = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration registers
    logic [sere_pkg::MODE_W-1:0] mode_reg;
    logic [1:0]                  axis_reg;
    logic [sere_pkg::CFG_W-1:0]  alen_reg;
    logic [sere_pkg::CFG_W-1:0]  stride0_reg;
    logic [sere_pkg::CFG_W-1:0]  stride1_reg;
    logic [sere_pkg::CFG_W-1:0]  stride2_reg;
    logic [sere_pkg::CFG_W-1:0]  stride3_reg;
    logic                        cfg_we;
    logic [sere_pkg::REG_IDX_W-1:0] cfg_idx;

    // captured transaction
    logic [sere_pkg::CMD_W-1:0]   cmd_reg;
    logic [11:0]                  addr_reg;
    logic [sere_pkg::COORD_W-1:0] coord_reg [4];
    logic [12:0]                  idx_reg;
    logic [DATA_WIDTH-1:0]        val_reg;
    logic [63:0]                  val_ext;

    // index and address generation
    logic [13:0]                  mag;
    logic                         idx_ok;
    logic                         axis_ok;
    logic [sere_pkg::POS_W-1:0]   pos;
    logic [sere_pkg::POS_W-1:0]   pos_reg;
    logic [sere_pkg::DIM_W-1:0]   dim_reg;
    logic [sere_pkg::DST_W-1:0]   dst_reg;
    logic [sere_pkg::DST_W-1:0]   dst_next;
    logic [sere_pkg::POS_W-1:0]   coord_sel;
    logic [sere_pkg::CFG_W-1:0]   stride_sel;
    logic [25:0]                  dim_prod;
    logic                         dst_ok;
    logic                         addr_ok;
    logic                         addr_init;
    logic                         addr_step;

    // store
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata_reg;

    // reduction
    sere_pkg::alu_ctl_t    alu_ctl;
    logic [DATA_WIDTH-1:0] alu_result;
    logic                  mul_last;

    // result staging and output register
    logic                          res_load;
    logic [31:0]                   res_data;
    logic [sere_pkg::STATUS_W-1:0] res_status;
    logic [31:0]                   res_data_reg;
    logic [sere_pkg::STATUS_W-1:0] res_status_reg;
    logic                          out_load;
    logic                          m_valid_reg;
    logic [31:0]                   m_read_data_reg;
    logic [sere_pkg::STATUS_W-1:0] m_status_reg;

    // APB
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= sere_pkg::MODE_ASSIGN;
            axis_reg    <= 2'd0;
            alen_reg    <= 13'd1;
            stride0_reg <= 13'd0;
            stride1_reg <= 13'd0;
            stride2_reg <= 13'd0;
            stride3_reg <= 13'd1;
        end else if (cfg_we) begin
            case (cfg_idx)
                sere_pkg::REG_MODE:    mode_reg    <= pwdata[2:0];
                sere_pkg::REG_AXIS:    axis_reg    <= pwdata[1:0];
                sere_pkg::REG_ALEN:    alen_reg    <= pwdata[12:0];
                sere_pkg::REG_STRIDE0: stride0_reg <= pwdata[12:0];
                sere_pkg::REG_STRIDE1: stride1_reg <= pwdata[12:0];
                sere_pkg::REG_STRIDE2: stride2_reg <= pwdata[12:0];
                sere_pkg::REG_STRIDE3: stride3_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sere_pkg::REG_MODE:    prdata = 32'(mode_reg);
            sere_pkg::REG_AXIS:    prdata = 32'(axis_reg);
            sere_pkg::REG_ALEN:    prdata = 32'(alen_reg);
            sere_pkg::REG_STRIDE0: prdata = 32'(stride0_reg);
            sere_pkg::REG_STRIDE1: prdata = 32'(stride1_reg);
            sere_pkg::REG_STRIDE2: prdata = 32'(stride2_reg);
            sere_pkg::REG_STRIDE3: prdata = 32'(stride3_reg);
            default:               prdata = 32'd0;
        endcase
    end

    // capture
    assign s_ready = (state_reg == ST_IDLE);
    assign val_ext = {{32{s_value[31]}}, s_value};

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg      <= s_cmd;
            addr_reg     <= s_flat_addr;
            coord_reg[0] <= s_coord0;
            coord_reg[1] <= s_coord1;
            coord_reg[2] <= s_coord2;
            coord_reg[3] <= s_coord3;
            idx_reg      <= s_axis_index;
            val_reg      <= DATA_WIDTH'(val_ext);
        end
    end

    // index wrap and range check
    assign mag     = 14'(14'd8192 - {1'b0, idx_reg});
    assign idx_ok  = idx_reg[12] ? (mag <= {1'b0, alen_reg}) : (idx_reg < alen_reg);
    assign axis_ok = (int'(axis_reg) < MAX_RANK);
    assign pos     = idx_reg[12] ? (alen_reg - mag[12:0]) : idx_reg;
    assign addr_ok = (32'(addr_reg) < 32'(DEPTH));
    assign dst_ok  = (32'(dst_reg) < 32'(DEPTH));

    always_comb begin
        case (dim_reg)
            2'd0:    stride_sel = stride0_reg;
            2'd1:    stride_sel = stride1_reg;
            2'd2:    stride_sel = stride2_reg;
            default: stride_sel = stride3_reg;
        endcase
    end

    assign coord_sel = (dim_reg == axis_reg) ? pos_reg : {1'b0, coord_reg[dim_reg]};
    assign dim_prod  = 26'(coord_sel) * 26'(stride_sel);
    assign dst_next  = dst_reg + sere_pkg::DST_W'(dim_prod);

    always_ff @(posedge aclk) begin
        if (addr_init) begin
            pos_reg <= pos;
            dst_reg <= '0;
            dim_reg <= '0;
        end else if (addr_step) begin
            dst_reg <= dst_next;
            dim_reg <= dim_reg + 2'd1;
        end
    end

    // store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    sere_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (alu_ctl),
        .old_val  (mem_rdata_reg),
        .upd_val  (val_reg),
        .result   (alu_result),
        .mul_last (mul_last)
    );

    // sequencer
    always_comb begin
        state_next        = state_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = ADDR_W'(dst_reg);
        mem_raddr         = ADDR_W'(dst_reg);
        mem_wdata         = alu_result;
        res_load          = 1'b0;
        res_data          = 32'd0;
        res_status        = sere_pkg::STAT_OK;
        addr_init         = 1'b0;
        addr_step         = 1'b0;
        out_load          = 1'b0;
        alu_ctl.mode      = mode_reg;
        alu_ctl.mul_clear = 1'b0;
        alu_ctl.mul_step  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (cmd_reg)
                    sere_pkg::CMD_WRITE: begin
                        res_load   = 1'b1;
                        state_next = ST_FIN;
                        if (addr_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(addr_reg);
                            mem_wdata = val_reg;
                            res_data  = 32'(val_reg);
                        end else begin
                            res_status = sere_pkg::STAT_BAD_ADDR;
                        end
                    end
                    sere_pkg::CMD_READ: begin
                        if (addr_ok) begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(addr_reg);
                            state_next = ST_RDWAIT;
                        end else begin
                            res_load   = 1'b1;
                            res_status = sere_pkg::STAT_BAD_ADDR;
                            state_next = ST_FIN;
                        end
                    end
                    sere_pkg::CMD_SCATTER: begin
                        if (idx_ok && axis_ok) begin
                            addr_init  = 1'b1;
                            state_next = ST_ADDR;
                        end else begin
                            res_load   = 1'b1;
                            res_status = sere_pkg::STAT_BAD_INDEX;
                            state_next = ST_FIN;
                        end
                    end
                    default: begin
                        res_load   = 1'b1;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_ADDR: begin
                addr_step = 1'b1;
                if (dim_reg == LAST_DIM) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (dst_ok) begin
                    mem_re     = 1'b1;
                    state_next = ST_RDWAIT;
                end else begin
                    res_load   = 1'b1;
                    res_status = sere_pkg::STAT_BAD_ADDR;
                    state_next = ST_FIN;
                end
            end
            ST_RDWAIT: begin
                if (cmd_reg == sere_pkg::CMD_READ) begin
                    res_load   = 1'b1;
                    res_data   = 32'(mem_rdata_reg);
                    state_next = ST_FIN;
                end else if (mode_reg == sere_pkg::MODE_MUL) begin
                    alu_ctl.mul_clear = 1'b1;
                    state_next        = ST_MUL;
                end else begin
                    mem_we     = 1'b1;
                    res_load   = 1'b1;
                    res_data   = 32'(alu_result);
                    state_next = ST_FIN;
                end
            end
            ST_MUL: begin
                alu_ctl.mul_step = 1'b1;
                if (mul_last) begin
                    mem_we     = 1'b1;
                    res_load   = 1'b1;
                    res_data   = 32'(alu_result);
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_data_reg   <= res_data;
            res_status_reg <= res_status;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_read_data_reg <= res_data_reg;
            m_status_reg    <= res_status_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;

    `SERE_ASSERT_NEXT(a_accept_to_exec, s_valid && s_ready, state_reg == ST_EXEC,
        "accepted transaction did not start")
    `SERE_ASSERT_IMPL(a_no_store_write_idle, state_reg == ST_IDLE || state_reg == ST_FIN,
        !mem_we, "store written outside a command")
    `SERE_ASSERT_NEXT(a_fin_delivers, state_reg == ST_FIN && (!m_valid_reg || m_ready),
        m_valid_reg && state_reg == ST_IDLE, "result not moved to output")
    `SERE_ASSERT_IMPL(a_status_legal, m_valid_reg,
        m_status_reg == sere_pkg::STAT_OK || m_status_reg == sere_pkg::STAT_BAD_INDEX
        || m_status_reg == sere_pkg::STAT_BAD_ADDR, "illegal status code")

endmodule

// ===== tb/sv/scatter_elements_reduce_unit_tb.sv =====
// Self-checking testbench for scatter_elements_reduce_unit: APB register setup,
// write/read/scatter command traffic with bursty sender and stalling receiver.
// Depends on sere_pkg and the RTL of scatter_elements_reduce_unit only.
module scatter_elements_reduce_unit_tb;

    localparam logic [sere_pkg::CMD_W-1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [sere_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [sere_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int STORE_DEPTH = 4096;

    typedef struct packed {
        logic [sere_pkg::CMD_W-1:0]        cmd;
        logic [sere_pkg::COORD_W-1:0]      flat_addr;
        logic [3:0][sere_pkg::COORD_W-1:0] coord;
        logic [sere_pkg::POS_W-1:0]        axis_index;
        logic [31:0]                       value;
    } command_t;

    typedef struct packed {
        logic [31:0]                   read_data;
        logic [sere_pkg::STATUS_W-1:0] status;
    } response_t;

    class scatter_checker;
        logic [sere_pkg::MODE_W-1:0] mode;
        logic [sere_pkg::DIM_W-1:0]  axis;
        logic [sere_pkg::CFG_W-1:0]  alen;
        logic [sere_pkg::CFG_W-1:0]  stride [4];
        logic [31:0]                 store [STORE_DEPTH];
        response_t                   pending_responses [$];
        int                          errors;

        function new();
            mode = sere_pkg::MODE_ASSIGN;
            axis = '0;
            alen = 13'd1;
            stride[0] = '0;
            stride[1] = '0;
            stride[2] = '0;
            stride[3] = 13'd1;
            errors = 0;
        endfunction

        function void set_reg(logic [sere_pkg::REG_IDX_W-1:0] idx,
                              logic [sere_pkg::CFG_W-1:0] v);
            case (idx)
                sere_pkg::REG_MODE:    mode = v[sere_pkg::MODE_W-1:0];
                sere_pkg::REG_AXIS:    axis = v[sere_pkg::DIM_W-1:0];
                sere_pkg::REG_ALEN:    alen = v;
                sere_pkg::REG_STRIDE0: stride[0] = v;
                sere_pkg::REG_STRIDE1: stride[1] = v;
                sere_pkg::REG_STRIDE2: stride[2] = v;
                sere_pkg::REG_STRIDE3: stride[3] = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] merge_value(logic [31:0] old, logic [31:0] upd);
            case (mode)
                sere_pkg::MODE_ADD: return old + upd;
                sere_pkg::MODE_MUL: return old * upd;
                sere_pkg::MODE_MIN: return ($signed(old) < $signed(upd)) ? old : upd;
                sere_pkg::MODE_MAX: return ($signed(upd) < $signed(old)) ? old : upd;
                default:  return upd;
            endcase
        endfunction

        // entry is -1 when the command touches no store entry
        function void locate_entry(input command_t c,
                                   output logic [sere_pkg::STATUS_W-1:0] st,
                                   output int entry);
            int unsigned mag;
            int unsigned pos;
            longint dst;
            bit ok;
            st = sere_pkg::STAT_OK;
            entry = -1;
            case (c.cmd)
                sere_pkg::CMD_WRITE, sere_pkg::CMD_READ: entry = int'(c.flat_addr);
                sere_pkg::CMD_SCATTER: begin
                    if (c.axis_index[sere_pkg::POS_W-1]) begin
                        mag = 8192 - c.axis_index;
                        ok = mag <= alen;
                        pos = ok ? alen - mag : 0;
                    end else begin
                        ok = c.axis_index < alen;
                        pos = c.axis_index;
                    end
                    dst = 0;
                    for (int d = 0; d < 4; d++) begin
                        dst += longint'((d == axis) ? pos : c.coord[d])
                               * longint'(stride[d]);
                    end
                    if (!ok) begin
                        st = sere_pkg::STAT_BAD_INDEX;
                    end else if (dst >= STORE_DEPTH) begin
                        st = sere_pkg::STAT_BAD_ADDR;
                    end else begin
                        entry = int'(dst);
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_command(command_t c);
            response_t r;
            logic [sere_pkg::STATUS_W-1:0] st;
            int entry;
            locate_entry(c, st, entry);
            r.status = st;
            r.read_data = '0;
            if (st == sere_pkg::STAT_OK) begin
                case (c.cmd)
                    sere_pkg::CMD_WRITE: begin
                        store[entry] = c.value;
                        r.read_data = c.value;
                    end
                    sere_pkg::CMD_READ: r.read_data = store[entry];
                    sere_pkg::CMD_SCATTER: begin
                        store[entry] = merge_value(store[entry], c.value);
                        r.read_data = store[entry];
                    end
                    default: ;
                endcase
            end
            pending_responses.push_back(r);
        endfunction

        function void check_response(logic [31:0] rd, logic [sere_pkg::STATUS_W-1:0] st);
            response_t want;
            if (pending_responses.size() == 0) begin
                errors++;
                $display("%0t: response expected none actual read_data %h status %0d",
                         $time, rd, st);
                return;
            end
            want = pending_responses.pop_front();
            if (want.read_data !== rd) begin
                errors++;
                $display("%0t: read_data expected %h actual %h", $time, want.read_data, rd);
            end
            if (want.status !== st) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [11:0]        s_flat_addr;
    logic [11:0]        s_coord0;
    logic [11:0]        s_coord1;
    logic [11:0]        s_coord2;
    logic [11:0]        s_coord3;
    logic signed [12:0] s_axis_index;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_read_data;
    logic [1:0]         m_status;

    scatter_elements_reduce_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_flat_addr(s_flat_addr),
        .s_coord0(s_coord0), .s_coord1(s_coord1), .s_coord2(s_coord2), .s_coord3(s_coord3),
        .s_axis_index(s_axis_index), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data), .m_status(m_status)
    );

    scatter_checker sb = new();
    bit             written [STORE_DEPTH];
    int             gen_dim [4];
    int unsigned    burst_left = 0;
    int unsigned    sent_count = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("scatter_elements_reduce_unit test failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_command({s_cmd, s_flat_addr, s_coord3, s_coord2, s_coord1, s_coord0,
                                 s_axis_index, s_value});
            if (m_valid && m_ready)
                sb.check_response(m_read_data, m_status);
        end
    end

    initial begin : receiver
        int pat;
        int len;
        int per;
        m_ready = 1'b0;
        forever begin
            pat = $urandom_range(0, 3);
            len = $urandom_range(16, 160);
            per = $urandom_range(2, 7);
            for (int k = 0; k < len; k++) begin
                @(negedge aclk);
                case (pat)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (k % per) != 0;
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    function automatic command_t rand_command();
        command_t c;
        c.cmd = 2'($urandom_range(0, 3));
        c.flat_addr = 12'($urandom);
        for (int d = 0; d < 4; d++) c.coord[d] = 12'($urandom);
        c.axis_index = 13'($urandom);
        c.value = $urandom;
        return c;
    endfunction

    function automatic command_t scatter_cmd(int c0, int c1, int c2, int c3,
                                             logic [12:0] idx, logic [31:0] v);
        command_t c;
        c = rand_command();
        c.cmd = sere_pkg::CMD_SCATTER;
        c.coord[0] = 12'(c0);
        c.coord[1] = 12'(c1);
        c.coord[2] = 12'(c2);
        c.coord[3] = 12'(c3);
        c.axis_index = idx;
        c.value = v;
        return c;
    endfunction

    function automatic command_t shaped_scatter();
        command_t c;
        int unsigned pos;
        c = rand_command();
        c.cmd = sere_pkg::CMD_SCATTER;
        c.value = rand_value();
        for (int d = 0; d < 4; d++) c.coord[d] = 12'($urandom_range(0, gen_dim[d] - 1));
        if (sb.alen != 0) begin
            pos = $urandom_range(0, sb.alen - 1);
            c.axis_index = $urandom_range(0, 1) ? 13'(pos) : 13'(pos) - sb.alen;
        end
        return c;
    endfunction

    task automatic send_txn(input command_t c);
        @(negedge aclk);
        if (burst_left == 0) begin
            if (s_valid) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 5)) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_cmd        <= c.cmd;
        s_flat_addr  <= c.flat_addr;
        s_coord0     <= c.coord[0];
        s_coord1     <= c.coord[1];
        s_coord2     <= c.coord[2];
        s_coord3     <= c.coord[3];
        s_axis_index <= c.axis_index;
        s_value      <= c.value;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic send_write(input int entry, input logic [31:0] v);
        command_t c;
        c = rand_command();
        c.cmd = sere_pkg::CMD_WRITE;
        c.flat_addr = 12'(entry);
        c.value = v;
        written[entry] = 1'b1;
        send_txn(c);
    endtask

    // load the target first so that no never-written entry is read
    task automatic send_checked(input command_t c);
        logic [sere_pkg::STATUS_W-1:0] st;
        int entry;
        sb.locate_entry(c, st, entry);
        if ((c.cmd == sere_pkg::CMD_READ || c.cmd == sere_pkg::CMD_SCATTER) && entry >= 0
            && !written[entry])
            send_write(entry, rand_value());
        if (c.cmd == sere_pkg::CMD_WRITE) written[c.flat_addr] = 1'b1;
        send_txn(c);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input bit is_write, input logic [sere_pkg::REG_IDX_W-1:0] idx,
                              input logic [sere_pkg::CFG_W-1:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(v);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (is_write) begin
            sb.set_reg(idx, v);
        end else if (prdata !== 32'(v)) begin
            sb.errors++;
            $display("%0t: register %0d expected %h actual %h", $time, idx, 32'(v), prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [sere_pkg::MODE_W-1:0] mode,
                              input logic [sere_pkg::DIM_W-1:0] axis,
                              input int alen, input int s0, input int s1, input int s2,
                              input int s3);
        logic [sere_pkg::CFG_W-1:0] vals [7];
        vals = '{13'(mode), 13'(axis), 13'(alen), 13'(s0), 13'(s1), 13'(s2), 13'(s3)};
        drain();
        for (int r = 0; r < 7; r++) apb_access(1'b1, sere_pkg::REG_IDX_W'(r), vals[r]);
        for (int r = 0; r < 7; r++) apb_access(1'b0, sere_pkg::REG_IDX_W'(r), vals[r]);
    endtask

    initial begin : stimulus
        command_t c;
        logic [sere_pkg::MODE_W-1:0] phase_mode [8];
        logic [sere_pkg::MODE_W-1:0] dir_mode [5];
        int e [4];
        int rem;
        int ax;
        int r;
        int i;
        int unsigned phase_end;
        phase_mode = '{sere_pkg::MODE_MAX, sere_pkg::MODE_ADD, sere_pkg::MODE_ASSIGN,
                       sere_pkg::MODE_MUL, sere_pkg::MODE_MIN, MODE_SPARE_LO,
                       sere_pkg::MODE_ADD, MODE_SPARE_HI};
        dir_mode = '{sere_pkg::MODE_ADD, sere_pkg::MODE_MUL, sere_pkg::MODE_MIN,
                     sere_pkg::MODE_MAX, MODE_SPARE_HI};
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_cmd = '0;
        s_flat_addr = '0;
        s_coord0 = '0;
        s_coord1 = '0;
        s_coord2 = '0;
        s_coord3 = '0;
        s_axis_index = '0;
        s_value = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // 8x8x8x8 tensor, scatter along dimension 1
        set_config(sere_pkg::MODE_ASSIGN, 2'd1, 8, 512, 64, 8, 1);
        send_write(0, 32'h7fff_ffff);
        send_write(STORE_DEPTH - 1, 32'h8000_0000);
        c = rand_command();
        c.cmd = sere_pkg::CMD_READ;
        c.flat_addr = 12'd0;
        send_checked(c);
        c.flat_addr = 12'hfff;
        send_checked(c);
        c = rand_command();
        c.cmd = CMD_UNUSED;
        send_checked(c);
        send_checked(scatter_cmd(1, 0, 2, 3, 13'h0007, 32'h1234_5678));
        send_checked(scatter_cmd(1, 0, 2, 3, 13'h1ff8, 32'hffff_ffff));
        send_checked(scatter_cmd(1, 0, 2, 3, 13'h0008, 32'h5));
        send_checked(scatter_cmd(1, 0, 2, 3, 13'h1ff7, 32'h5));
        send_checked(scatter_cmd(7, 0, 7, 7, 13'h0fff, 32'h5));
        send_checked(scatter_cmd(7, 0, 7, 7, 13'h1000, 32'h5));
        send_checked(scatter_cmd(4095, 4095, 4095, 4095, 13'h0000, 32'h5));
        // bad index wins over bad address
        send_checked(scatter_cmd(4095, 4095, 4095, 4095, 13'h0008, 32'h5));
        for (int m = 0; m < 5; m++) begin
            set_config(dir_mode[m], 2'd1, 8, 512, 64, 8, 1);
            send_checked(scatter_cmd(0, 0, 0, 0, 13'h0000, 32'h8000_0000));
            send_checked(scatter_cmd(0, 0, 0, 0, 13'h1ff8, 32'h7fff_ffff));
        end
        // zero axis length rejects every index
        set_config(sere_pkg::MODE_ADD, 2'd0, 0, 1, 0, 0, 0);
        send_checked(scatter_cmd(0, 0, 0, 0, 13'h0000, 32'h1));

        for (int p = 0; p < 8; p++) begin
            ax = $urandom_range(0, 3);
            if (p == 0) begin
                gen_dim = '{1, 1, 1, STORE_DEPTH};
                set_config(phase_mode[p], 2'd3, STORE_DEPTH, 0, 0, 0, 1);
            end else if (p == 1) begin
                gen_dim = '{1, 1, 1, 1};
                set_config(phase_mode[p], 2'd0, 1, STORE_DEPTH, STORE_DEPTH, STORE_DEPTH,
                           STORE_DEPTH);
            end else if (p == 2) begin
                gen_dim = '{4, 4, 4, 4};
                set_config(phase_mode[p], 2'd2, 1, 0, 0, 0, 0);
            end else begin
                rem = 12;
                for (int d = 0; d < 4; d++) begin
                    e[d] = $urandom_range(0, rem > 5 ? 5 : rem);
                    rem -= e[d];
                end
                for (int d = 0; d < 4; d++) gen_dim[d] = 1 << e[d];
                set_config(phase_mode[p], 2'(ax),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, STORE_DEPTH)
                                                       : gen_dim[ax],
                           gen_dim[1] * gen_dim[2] * gen_dim[3], gen_dim[2] * gen_dim[3],
                           gen_dim[3], 1);
            end
            phase_end = sent_count + 135;
            i = 0;
            while (sent_count < phase_end) begin
                if (p == 4 && i == 60) drain();
                r = $urandom_range(0, 99);
                c = rand_command();
                if (r < 12) begin
                    c.cmd = sere_pkg::CMD_WRITE;
                    c.value = rand_value();
                end else if (r < 24) begin
                    c.cmd = sere_pkg::CMD_READ;
                end else if (r < 28) begin
                    c.cmd = CMD_UNUSED;
                end else if (r < 42) begin
                    c.cmd = sere_pkg::CMD_SCATTER;
                end else begin
                    c = shaped_scatter();
                end
                send_checked(c);
                i++;
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("scatter_elements_reduce_unit test passed");
        end else begin
            $display("scatter_elements_reduce_unit test failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/sere_pkg.sv
rtl/sere_alu.sv
rtl/scatter_elements_reduce_unit.sv
tb/sv/scatter_elements_reduce_unit_tb.sv
